/* rtl/core/wfcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wfcc_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int POS_W  = 4;
  localparam int STN_W  = 3;

  localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
  localparam logic [POS_W-1:0] POS_FIRST  = 4'd0;
  localparam logic [POS_W-1:0] POS_CRC_LO = 4'd5;
  localparam logic [POS_W-1:0] POS_RX_HI  = 4'd6;
  localparam logic [POS_W-1:0] POS_RX_LO  = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST   = 4'd9;

  typedef struct packed {
    logic [BYTE_W-1:0] air_byte;
    logic              frame_start;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  byte_index;
    logic              frame_done;
    logic              crc_good;
    logic              via_repeater;
    logic [STN_W-1:0]  station_id;
  } out_word_t;

  function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  // msb-first crc-16 over one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/wfcc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface wfcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [wfcc_pkg::BYTE_W-1:0] air_byte;
  logic                       frame_start;

  modport source (output valid, output air_byte, output frame_start, input ready);
  modport sink (input valid, input air_byte, input frame_start, output ready);
endinterface

interface wfcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [wfcc_pkg::BYTE_W-1:0] data_byte;
  logic [wfcc_pkg::POS_W-1:0]  byte_index;
  logic                        frame_done;
  logic                        crc_good;
  logic                        via_repeater;
  logic [wfcc_pkg::STN_W-1:0]  station_id;

  modport source (output valid, output data_byte, output byte_index, output frame_done,
                  output crc_good, output via_repeater, output station_id, input ready);
  modport sink (input valid, input data_byte, input byte_index, input frame_done,
                input crc_good, input via_repeater, input station_id, output ready);
endinterface
`default_nettype wire

/* rtl/core/wfcc_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module wfcc_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire wfcc_pkg::in_word_t in_word,
  output      logic               s_valid,
  input  wire logic               s_ready,
  output      wfcc_pkg::in_word_t s_word
);
  import wfcc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  assign in_ready  = !valid_r || s_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= in_word;
    end
  end

  assign s_valid = valid_r;
  assign s_word  = word_r;
endmodule
`default_nettype wire

/* rtl/core/wfcc_frame_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module wfcc_frame_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [wfcc_pkg::CRC_W-1:0]    crc_start,
  input  wire logic                          s_valid,
  output      logic                          s_ready,
  input  wire wfcc_pkg::in_word_t            s_word,
  output      logic                          r_valid,
  input  wire logic                          r_ready,
  output      wfcc_pkg::out_word_t           r_word
);
  import wfcc_pkg::*;

  logic [POS_W-1:0]  position_r, position_nxt;
  logic [CRC_W-1:0]  running_r, running_nxt;
  logic [CRC_W-1:0]  received_r, received_nxt;
  logic              direct_r, direct_nxt;
  logic [STN_W-1:0]  station_r, station_nxt;
  logic              valid_r;
  out_word_t         word_r, word_nxt;

  logic              take;
  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] rev;
  logic [CRC_W-1:0]  crc_base;
  logic [CRC_W-1:0]  crc_upd;
  logic              ext_match;

  assign s_ready = !valid_r || r_ready;
  assign take    = s_valid && s_ready;

  assign rev       = flip_byte(s_word.air_byte);
  assign pos       = (s_word.frame_start || position_r > POS_LAST) ? POS_FIRST : position_r;
  assign crc_base  = (pos == POS_FIRST) ? crc_start : running_r;
  assign crc_upd   = crc_byte(crc_base, rev);
  assign ext_match = (crc_upd == received_r);

  always_comb begin
    running_nxt  = crc_base;
    received_nxt = received_r;
    direct_nxt   = direct_r;
    station_nxt  = (pos == POS_FIRST) ? rev[STN_W-1:0] : station_r;
    position_nxt = (pos >= POS_LAST) ? POS_FIRST : pos + 1'b1;

    word_nxt.data_byte    = rev;
    word_nxt.byte_index   = pos;
    word_nxt.frame_done   = 1'b0;
    word_nxt.crc_good     = 1'b0;
    word_nxt.via_repeater = 1'b0;
    word_nxt.station_id   = station_nxt;

    if (pos <= POS_CRC_LO) begin
      running_nxt = crc_upd;
    end else if (pos == POS_RX_HI) begin
      received_nxt = {rev, {(CRC_W-BYTE_W){1'b0}}};
    end else if (pos == POS_RX_LO) begin
      received_nxt = {received_r[CRC_W-1:BYTE_W], rev};
      direct_nxt   = (running_r == {received_r[CRC_W-1:BYTE_W], rev});
    end else begin
      running_nxt = crc_upd;
      if (pos == POS_LAST) begin
        word_nxt.frame_done   = 1'b1;
        word_nxt.crc_good     = (direct_r || ext_match) && (received_r != '0);
        word_nxt.via_repeater = !direct_r && ext_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      position_r <= POS_FIRST;
      running_r  <= '0;
      received_r <= '0;
      direct_r   <= 1'b0;
      station_r  <= '0;
    end else begin
      if (s_ready) begin
        valid_r <= s_valid;
      end
      if (take) begin
        position_r <= position_nxt;
        running_r  <= running_nxt;
        received_r <= received_nxt;
        direct_r   <= direct_nxt;
        station_r  <= station_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

  assign r_valid = valid_r;
  assign r_word  = word_r;
endmodule
`default_nettype wire

/* rtl/core/weather_frame_crc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Radio frame checker: takes one over-the-air byte per word, LSB first, and returns one
// word per byte with the byte bit-reversed, its index 0..9 in the frame, and the station
// id from byte 0. CRC-16 (poly 0x1021, start value from cfg_data) runs over bytes 0-5 and
// is compared with bytes 6-7; it is also carried over bytes 8-9 for repeater
// frames. The verdict (crc_good, via_repeater) is valid only on the word with frame_done.
// A zero received CRC is always rejected. frame_start restarts a frame at any point.
// Throughput is one byte per cycle while the output is not stalled; each word passes an
// input register and then a result register, with the byte-wide CRC update between
// them. A stalled result holds both registers.
module weather_frame_crc_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wfcc_in_if.sink                         in_ch,
  wfcc_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [wfcc_pkg::CRC_W-1:0] cfg_data
);
  import wfcc_pkg::*;

  logic [CRC_W-1:0] crc_start_r;
  in_word_t         in_word;
  in_word_t         s_word;
  logic             s_valid;
  logic             s_ready;
  out_word_t        r_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_start_r <= '0;
    end else if (cfg_we) begin
      crc_start_r <= cfg_data;
    end
  end

  assign in_word.air_byte    = in_ch.air_byte;
  assign in_word.frame_start = in_ch.frame_start;

  wfcc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_word),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_word   (s_word)
  );

  wfcc_frame_stage u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_start (crc_start_r),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_word    (s_word),
    .r_valid   (out_ch.valid),
    .r_ready   (out_ch.ready),
    .r_word    (r_word)
  );

  assign out_ch.data_byte    = r_word.data_byte;
  assign out_ch.byte_index   = r_word.byte_index;
  assign out_ch.frame_done   = r_word.frame_done;
  assign out_ch.crc_good     = r_word.crc_good;
  assign out_ch.via_repeater = r_word.via_repeater;
  assign out_ch.station_id   = r_word.station_id;

  a_done_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |-> out_ch.byte_index == POS_LAST)
    else $error("frame_done off the last byte");

  a_verdict_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.frame_done |-> !out_ch.crc_good && !out_ch.via_repeater)
    else $error("verdict outside frame end");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.byte_index <= POS_LAST)
    else $error("byte index out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s_valid)
    else $error("accepted word lost at input stage");
endmodule
`default_nettype wire

/* dv/weather_frame_crc_checker_tb.sv */
`timescale 1ns / 1ps
module weather_frame_crc_checker_tb;
  import wfcc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int FRAME_LEN   = POS_LAST + 1;

  typedef enum int {
    FR_DIRECT,
    FR_REPEATER,
    FR_CORRUPT,
    FR_ZERO_DIRECT,
    FR_ZERO_REPEATER
  } frame_kind_e;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CRC_W-1:0] cfg_data;

  wfcc_in_if  in_bus ();
  wfcc_out_if out_bus ();

  weather_frame_crc_checker DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // frame checker mirror state
  logic [CRC_W-1:0] crc_seed   = '0;
  logic [CRC_W-1:0] crc_acc    = '0;
  logic [CRC_W-1:0] rx_crc     = '0;
  logic [POS_W-1:0] frame_pos  = '0;
  logic             direct_hit = 1'b0;
  logic [STN_W-1:0] stn_latch  = '0;

  out_word_t expected_words[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_asked      = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int cycles          = 0;
  int words_sent      = 0;
  int words_checked   = 0;
  int good_frames     = 0;
  int repeater_frames = 0;
  int errors          = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("weather_frame_crc_checker test failed");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) r = {r[BYTE_W-2:0], v[i]};
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = c;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ b[i];
      r  = {r[CRC_W-2:0], 1'b0} ^ ({CRC_W{fb}} & CRC_POLY);
    end
    return r;
  endfunction

  function automatic out_word_t predict_frame_byte(input logic [BYTE_W-1:0] air,
                                                   input logic fs);
    out_word_t        o;
    logic [BYTE_W-1:0] d;
    logic [POS_W-1:0]  p;
    logic              ext;
    o = '0;
    d = mirror8(air);
    if (fs || frame_pos > POS_LAST) frame_pos = POS_FIRST;
    p = frame_pos;
    if (p == POS_FIRST) begin
      crc_acc   = crc_seed;
      stn_latch = d[STN_W-1:0];
    end
    if (p <= POS_CRC_LO) begin
      crc_acc = crc_next(crc_acc, d);
    end else if (p == POS_RX_HI) begin
      rx_crc = {d, 8'h00};
    end else if (p == POS_RX_LO) begin
      rx_crc     = rx_crc | {8'h00, d};
      direct_hit = (crc_acc == rx_crc);
    end else begin
      crc_acc = crc_next(crc_acc, d);
      if (p == POS_LAST) begin
        ext            = (crc_acc == rx_crc);
        o.frame_done   = 1'b1;
        o.crc_good     = (direct_hit || ext) && (rx_crc != '0);
        o.via_repeater = !direct_hit && ext;
      end
    end
    frame_pos    = (p >= POS_LAST) ? POS_FIRST : p + 1'b1;
    o.data_byte  = d;
    o.byte_index = p;
    o.station_id = stn_latch;
    return o;
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] air, input logic fs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_bus.valid       <= 1'b0;
      in_bus.air_byte    <= BYTE_W'($urandom_range(255));
      in_bus.frame_start <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.air_byte    <= air;
    in_bus.frame_start <= fs;
    do @(posedge clk); while (!in_bus.ready);
    expected_words.push_back(predict_frame_byte(air, fs));
    words_sent++;
  endtask

  // bytes are built in received order, sent mirrored as on air
  task automatic send_frame(input frame_kind_e kind, input logic use_start,
                            input logic [BYTE_W-1:0] first);
    logic [BYTE_W-1:0] d [FRAME_LEN];
    logic [CRC_W-1:0]  c;
    logic [CRC_W-1:0]  rx;
    d[0] = first;
    for (int i = 1; i < FRAME_LEN; i++) d[i] = BYTE_W'($urandom_range(255));
    if (kind == FR_ZERO_DIRECT) begin
      c = crc_seed;
      for (int i = 0; i < 4; i++) c = crc_next(c, d[i]);
      d[4] = c[15:8];
      d[5] = c[7:0];
    end
    c = crc_seed;
    for (int i = 0; i <= POS_CRC_LO; i++) c = crc_next(c, d[i]);
    case (kind)
      FR_DIRECT:        rx = c;
      FR_REPEATER:      rx = crc_next(crc_next(c, d[8]), d[9]);
      FR_CORRUPT:       rx = CRC_W'($urandom_range(16'hFFFF));
      FR_ZERO_DIRECT:   rx = '0;
      FR_ZERO_REPEATER: begin
        d[8] = c[15:8];
        d[9] = c[7:0];
        rx   = '0;
      end
      default:          rx = c;
    endcase
    d[POS_RX_HI] = rx[15:8];
    d[POS_RX_LO] = rx[7:0];
    for (int i = 0; i < FRAME_LEN; i++) send_word(mirror8(d[i]), use_start && (i == 0));
  endtask

  task automatic load_start_value(input logic [CRC_W-1:0] v);
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    crc_seed = v;
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
      errors++;
    end
  endtask

  task automatic test_directed_frames();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(FR_DIRECT, 1'b1, 8'hFF);
    // no frame_start: wraps into byte 0, zero crc that only the repeater path matches
    send_frame(FR_ZERO_REPEATER, 1'b0, 8'h00);
    // partial frame, abandoned by the next frame_start
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b0);
  endtask

  task automatic test_random_traffic(input int sidle, input int rstall,
                                     input logic [CRC_W-1:0] start_val, input int n_words);
    int   budget;
    int   n_noise;
    logic fresh;
    load_start_value(start_val);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    budget         = 0;
    while (budget < n_words) begin
      if ($urandom_range(99) < 80) begin
        fresh = (frame_pos != POS_FIRST) || $urandom_range(1);
        send_frame(frame_kind_e'($urandom_range(4)), fresh, BYTE_W'($urandom_range(255)));
        budget += FRAME_LEN;
      end else begin
        n_noise = $urandom_range(12, 1);
        repeat (n_noise) send_word(BYTE_W'($urandom_range(255)), $urandom_range(99) < 20);
        budget += n_noise;
      end
    end
  endtask

  task automatic test_output_backpressure();
    load_start_value(16'h1D0F);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    repeat (4) begin
      send_frame(frame_kind_e'($urandom_range(4)), 1'b1, BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : result_check
    out_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected, data_byte %0h", out_bus.data_byte);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("data_byte", 16'(want.data_byte), 16'(out_bus.data_byte));
          check_field("byte_index", 16'(want.byte_index), 16'(out_bus.byte_index));
          check_field("frame_done", 16'(want.frame_done), 16'(out_bus.frame_done));
          check_field("crc_good", 16'(want.crc_good), 16'(out_bus.crc_good));
          check_field("via_repeater", 16'(want.via_repeater), 16'(out_bus.via_repeater));
          check_field("station_id", 16'(want.station_id), 16'(out_bus.station_id));
          words_checked++;
          if (want.crc_good) good_frames++;
          if (want.via_repeater) repeater_frames++;
        end
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.air_byte    <= '0;
    in_bus.frame_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_random_traffic(0, 0, 16'hFFFF, 400);
    test_random_traffic(46, 0, 16'h0000, 400);
    test_random_traffic(0, 46, CRC_W'($urandom_range(16'hFFFF)), 400);
    test_random_traffic(23, 23, CRC_W'($urandom_range(16'hFFFF)), 400);
    test_output_backpressure();

    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d words sent, %0d results checked; start values 0x0000, 0xFFFF and random",
             words_sent, words_checked);
    $display("%0d frames with good crc, %0d via repeater; one %0d-cycle output hold",
             good_frames, repeater_frames, HOLD_CYCLES);
    if (errors == 0) begin
      $display("weather_frame_crc_checker test passed");
    end else begin
      $display("weather_frame_crc_checker test failed");
    end
    $finish;
  end

endmodule
